// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Sobel edge block. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Condition must never hold.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Types, widths and register codes shared by the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 12;
    localparam int IN_ROW_W       = 12;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } pix_out_t;

    // 3x3 neighborhood, entry 0 top left, entry 8 bottom right.
    typedef logic [8:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] value;
    } mag_rsp_t;

endpackage

// File: rtl/sobel_line_mem.sv
// ----------------------------------------------------------------------------
// sobel_line_mem
// Single-port-write, registered-read memory holding both line stores, one
// column per entry, older line in the upper byte.
// ----------------------------------------------------------------------------
module sobel_line_mem #(
    parameter int DEPTH  = sobel_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 2 * sobel_pkg::PIX_W
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/sobel_mag.sv
// ----------------------------------------------------------------------------
// sobel_mag
// Gradient magnitude unit: Sobel sums, two squares, then an integer square
// root found one result bit per cycle, saturated to 255.
// ----------------------------------------------------------------------------
module sobel_mag (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sobel_pkg::win_t    win,
    output sobel_pkg::mag_rsp_t rsp
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_SQ   = 4'b0010,
        M_SUM  = 4'b0100,
        M_ROOT = 4'b1000
    } mstate_t;

    mstate_t     state_reg, state_next;
    logic [9:0]  right_sum, left_sum, bottom_sum, top_sum;
    logic [9:0]  ax_reg, ay_reg;
    logic [19:0] sqx_reg, sqy_reg;
    logic [20:0] sq_sum;
    logic [15:0] rad_reg;
    logic [7:0]  root_reg;
    logic [2:0]  bit_reg;
    logic [7:0]  trial;
    logic [15:0] trial_sq;
    logic [7:0]  root_next;
    logic        done_reg;
    logic [7:0]  value_reg;

    assign right_sum  = {2'b00, win[2]} + {1'b0, win[5], 1'b0} + {2'b00, win[8]};
    assign left_sum   = {2'b00, win[0]} + {1'b0, win[3], 1'b0} + {2'b00, win[6]};
    assign bottom_sum = {2'b00, win[6]} + {1'b0, win[7], 1'b0} + {2'b00, win[8]};
    assign top_sum    = {2'b00, win[0]} + {1'b0, win[1], 1'b0} + {2'b00, win[2]};

    assign sq_sum    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign trial     = root_reg | (8'd1 << bit_reg);
    assign trial_sq  = {8'd0, trial} * {8'd0, trial};
    assign root_next = (trial_sq <= rad_reg) ? trial : root_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_SQ;
                end
            end
            M_SQ:
            begin
                state_next = M_SUM;
            end
            M_SUM:
            begin
                // Anything at or above 256 squared saturates at once.
                state_next = (sq_sum[20:16] != 5'd0) ? M_IDLE : M_ROOT;
            end
            M_ROOT:
            begin
                if (bit_reg == 3'd0)
                begin
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == M_SUM) && (sq_sum[20:16] != 5'd0)) ||
                         ((state_reg == M_ROOT) && (bit_reg == 3'd0));
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == M_IDLE) && start)
        begin
            ax_reg <= (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
            ay_reg <= (bottom_sum >= top_sum) ? bottom_sum - top_sum : top_sum - bottom_sum;
        end
        if (state_reg == M_SQ)
        begin
            sqx_reg <= {10'd0, ax_reg} * {10'd0, ax_reg};
            sqy_reg <= {10'd0, ay_reg} * {10'd0, ay_reg};
        end
        if (state_reg == M_SUM)
        begin
            rad_reg   <= sq_sum[15:0];
            root_reg  <= 8'd0;
            bit_reg   <= 3'd7;
            value_reg <= 8'hFF;
        end
        if (state_reg == M_ROOT)
        begin
            root_reg  <= root_next;
            bit_reg   <= bit_reg - 3'd1;
            value_reg <= root_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

// File: rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel edge magnitude over 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the in_valid / in_ready channel, one item per pixel, with
// frame_start set on the first pixel of each frame. After the last pixel the
// host sends image_width + 1 drain items so the final rows flush out. Results
// leave on out_valid / out_ready; frame_last marks the last pixel of a frame,
// after which items without frame_start are taken and dropped.
// Both line stores share one memory with a registered read, so an item reads
// its column on accept and writes it back in the cycle after. An item with no
// result then returns to idle; a border pixel, or an inner pixel once the
// square root unit (one result bit per cycle, skipped when the sum of squares
// saturates) is done, goes to the output register as soon as that is free. An
// item whose frame is already done is taken and dropped at once.
// Reset sets the registers to 640 x 480 and then clears the line memory,
// one column per cycle, through all MAX_WIDTH columns; in_ready stays low meanwhile.
// Configuration writes are taken at any time but belong between frames.
// The output register frees the input side: a new item is accepted while a
// result waits, and only when a second result is ready does the block hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sobel_pkg::pix_in_t           in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output sobel_pkg::pix_out_t          out_item,
    input  logic                         cfg_write,
    input  logic [0:0]                   cfg_index,
    input  logic [sobel_pkg::CFG_W-1:0]  cfg_data
);

    localparam int PW    = sobel_pkg::PIX_W;
    localparam int RW    = sobel_pkg::IN_ROW_W;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int WHB   = (WB > HB) ? WB : HB;
    // Common width for the frame size and all compares against it.
    localparam int DIM_W = ((WHB > sobel_pkg::CFG_W) ? WHB : sobel_pkg::CFG_W) + 1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_MAG   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [sobel_pkg::CFG_W-1:0]   width_reg, height_reg;
    logic [COL_W-1:0]              clr_reg, clr_next;
    logic [COL_W-1:0]              in_col_reg, in_col_next;
    logic [RW-1:0]                 in_row_reg, in_row_next;
    logic [COL_W-1:0]              out_col_reg, out_col_next;
    logic [ROW_W-1:0]              out_row_reg, out_row_next;
    logic                          frame_done_reg, frame_done_next;
    logic                          pend_last_reg, pend_last_next;
    logic                          mag_go_reg, mag_go_next;
    logic                          out_valid_reg, out_valid_next;
    sobel_pkg::win_t               win_reg, win_next;
    logic [PW-1:0]                 bot_reg;
    logic [PW-1:0]                 pend_val_reg;
    sobel_pkg::pix_out_t           out_item_reg;
    sobel_pkg::mag_rsp_t           mag_rsp;

    logic [DIM_W-1:0]              w_raw, h_raw, wd, ht;
    logic                          in_acc, start, out_free, out_load;
    logic [COL_W-1:0]              col_eff;
    logic [RW-1:0]                 row_eff;
    logic [2*PW-1:0]               rd_data, wr_data;
    logic                          wr_en;
    logic [COL_W-1:0]              wr_addr;
    logic [PW-1:0]                 line_top, line_mid;
    logic                          emit, border, last, in_col_wrap, out_col_wrap;

    // ------------------------------------------------------------------
    // Configuration registers and effective frame size. A size of zero acts
    // as one; a size beyond the build maximum acts as the maximum.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sobel_pkg::RST_IMAGE_WIDTH;
            height_reg <= sobel_pkg::RST_IMAGE_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sobel_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                sobel_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                     width_reg  <= width_reg;
            endcase
        end
    end

    assign w_raw = DIM_W'(width_reg);
    assign h_raw = DIM_W'(height_reg);
    assign wd = (w_raw == '0) ? DIM_W'(1) :
                (w_raw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_raw;
    assign ht = (h_raw == '0) ? DIM_W'(1) :
                (h_raw > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_raw;

    // ------------------------------------------------------------------
    // Input side. A frame start clears the counters before the item is used.
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign start    = in_item.frame_start;
    assign col_eff  = start ? '0 : in_col_reg;
    assign row_eff  = start ? '0 : in_row_reg;

    // ------------------------------------------------------------------
    // Line memory: read the column on accept, write it back in the next cycle
    // with the middle line moved up and the new pixel below it. Only one item
    // is in flight, so the next read always sees the written entry.
    // ------------------------------------------------------------------
    assign line_top = rd_data[2*PW-1:PW];
    assign line_mid = rd_data[PW-1:0];
    assign wr_en    = (state_reg == S_CLEAR) || (state_reg == S_READ);
    assign wr_addr  = (state_reg == S_CLEAR) ? clr_reg : in_col_reg;
    assign wr_data  = (state_reg == S_CLEAR) ? '0 : {line_mid, bot_reg};

    sobel_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (2 * PW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_eff),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Window shifts left by one column as each item is written back.
    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = line_top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = line_mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = bot_reg;
    end

    // ------------------------------------------------------------------
    // Position decode for the item being written back. The output trails the
    // input by one row and one column.
    // ------------------------------------------------------------------
    assign emit = (in_row_reg >= RW'(2)) ||
                  ((in_row_reg == RW'(1)) && (in_col_reg != '0));
    assign out_col_wrap = (DIM_W'(out_col_reg) + DIM_W'(1)) >= wd;
    assign in_col_wrap  = (DIM_W'(in_col_reg) + DIM_W'(1)) >= wd;
    assign last   = ((DIM_W'(out_row_reg) + DIM_W'(1)) >= ht) && out_col_wrap;
    assign border = (out_row_reg == '0) || ((DIM_W'(out_row_reg) + DIM_W'(1)) >= ht) ||
                    (out_col_reg == '0) || out_col_wrap;

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_OUT) && out_free;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        frame_done_next = frame_done_reg;
        pend_last_next  = pend_last_reg;
        mag_go_next     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + COL_W'(1);
                if (clr_reg == COL_W'(MAX_WIDTH - 1))
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (start)
                    begin
                        in_col_next     = '0;
                        in_row_next     = '0;
                        out_col_next    = '0;
                        out_row_next    = '0;
                        frame_done_next = 1'b0;
                    end
                    // Once the frame is done, items are taken without effect.
                    if (start || !frame_done_reg)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (in_col_wrap)
                begin
                    in_col_next = '0;
                    if (in_row_reg != '1)
                    begin
                        in_row_next = in_row_reg + RW'(1);
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (emit)
                begin
                    pend_last_next = last;
                    if (last)
                    begin
                        frame_done_next = 1'b1;
                    end
                    else if (out_col_wrap)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                    if (border)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        mag_go_next = 1'b1;
                        state_next  = S_MAG;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MAG:
            begin
                if (mag_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            frame_done_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            mag_go_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            win_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            frame_done_reg <= frame_done_next;
            pend_last_reg  <= pend_last_next;
            mag_go_reg     <= mag_go_next;
            out_valid_reg  <= out_valid_next;
            if (state_reg == S_READ)
            begin
                win_reg <= win_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            // Items past the last row are drains and carry a zero pixel.
            bot_reg <= (DIM_W'(row_eff) >= ht) ? '0 : in_item.pixel_in;
        end
        if ((state_reg == S_READ) && border)
        begin
            // Border pixels pass the window center through unchanged.
            pend_val_reg <= win_next[4];
        end
        else if ((state_reg == S_MAG) && mag_rsp.done)
        begin
            pend_val_reg <= mag_rsp.value;
        end
        if (out_load)
        begin
            out_item_reg.pixel_out  <= pend_val_reg;
            out_item_reg.frame_last <= pend_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Magnitude unit, started by the registered go flag once the window has shifted.
    // ------------------------------------------------------------------
    sobel_mag u_mag (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mag_go_reg),
        .win   (win_reg),
        .rsp   (mag_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_out_no_overwrite, clk, rst_n, out_load, !out_valid_reg || out_ready, "output register overwritten")
    `ASSERT_IMPLY(a_mag_done_in_wait, clk, rst_n, mag_rsp.done, state_reg == S_MAG, "magnitude result with no waiting item")
    `ASSERT_IMPLY(a_done_after_last, clk, rst_n, $rose(frame_done_reg), pend_last_reg, "frame ended without a last pixel pending")
    `ASSERT_NEVER(a_no_accept_clear, clk, rst_n, in_acc && (clr_reg != '0), "item accepted during memory clear")

endmodule
